// ===== src/rwe_pkg.sv =====
// Shared types and constants for the rolling window extremum block.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package rwe_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 7;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 1'b1;

  // Mode codes.
  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Request bundle for the history memory: one write and one read port.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    sample_t           wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== src/rolling_window_extremum.sv =====
// Top level of the rolling window extremum block: sequencer and registers.
// Depends on rwe_pkg, rwe_hist_mem and rwe_cmp.
//
//   channel | direction | signals                          | accepted when
//   --------+-----------+----------------------------------+----------------------
//   in      | input     | in_valid, in_ready, in_sample    | in_valid & in_ready
//   out     | output    | out_valid, out_ready, out_extremum, out_covered
//           |           |                                  | out_valid & out_ready
//   cfg     | input     | cfg_we, cfg_index, cfg_wdata     | cfg_we
//
// When the new sample is merged into the running extremum, the result passes
// through ST_LEAVE, ST_MERGE and ST_OUT before it is written. A rescan reads
// one stored sample a cycle through the single read port of the history
// memory, compares it in the one shared comparator, and retires the last read
// before the result is written in ST_OUT. The block is ready for the next
// word as soon as the result is written.
// Reset is synchronous and active low; the history memory is not cleared,
// since the contents of slots not yet written are never used.
// A finished result sits in the output register while the next word is
// accepted; the block only stalls at the end of a word if that register is
// still full.
`default_nettype none
module rolling_window_extremum (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire rwe_pkg::sample_t             in_sample,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output rwe_pkg::sample_t                  out_extremum,
  output logic [rwe_pkg::WIN_W-1:0]         out_covered,
  input  wire logic                         cfg_we,
  input  wire logic [rwe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rwe_pkg::WIN_W-1:0]    cfg_wdata
);
  import rwe_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a word
  localparam logic [2:0] ST_LEAVE = 3'd1;  // leaving sample read back, decide
  localparam logic [2:0] ST_MERGE = 3'd2;  // merge new sample into extremum
  localparam logic [2:0] ST_SCAN  = 3'd3;  // walk back over the window
  localparam logic [2:0] ST_OUT   = 3'd4;  // hand the result to the output

  logic [2:0]        state_r, state_nxt;

  // Configuration.
  logic [WIN_W-1:0]  win_len_r, win_len_nxt;
  logic              mode_r, mode_nxt;
  logic              rescan_pend_r, rescan_pend_nxt;

  // Ring bookkeeping.
  logic [SLOT_W-1:0] ws_r, ws_nxt;
  logic [WIN_W-1:0]  fill_r, fill_nxt;

  // Per-word working registers.
  sample_t           samp_r, samp_nxt;
  sample_t           cur_r, cur_nxt;
  logic [WIN_W-1:0]  covered_r, covered_nxt;
  logic [SLOT_W-1:0] base_r, base_nxt;
  logic              full_r, full_nxt;
  logic              first_r, first_nxt;
  logic [SLOT_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [WIN_W-1:0]  scan_left_r, scan_left_nxt;
  logic              rd_pend_r, rd_pend_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  sample_t           out_ext_r, out_ext_nxt;
  logic [WIN_W-1:0]  out_cov_r, out_cov_nxt;

  // Derived values.
  logic [WIN_W-1:0]  win_eff;
  logic [WIN_W-1:0]  fill_inc;
  logic [SLOT_W-1:0] leave_addr;
  logic              in_acc;

  mem_req_t          mreq;
  sample_t           rd_data;
  sample_t           cmp_a, cmp_b;
  logic              cmp_better;

  rwe_hist_mem u_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  rwe_cmp u_cmp (
    .a      (cmp_a),
    .b      (cmp_b),
    .mode   (mode_r),
    .better (cmp_better)
  );

  // A window length of zero acts as one, and anything past the ring depth
  // is clipped to the ring depth.
  always_comb begin
    if (win_len_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_len_r > WIN_MAX) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = win_len_r;
    end
  end

  assign fill_inc   = (fill_r == WIN_MAX) ? fill_r : fill_r + WIN_W'(1);
  // With a full-depth window the leaving slot is the one being overwritten;
  // the memory reads before it writes, so the old sample comes back.
  assign leave_addr = ws_r - win_eff[SLOT_W-1:0];
  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;

  // Operand selection for the shared comparator.
  always_comb begin
    cmp_a = rd_data;
    cmp_b = cur_r;
    case (state_r)
      ST_LEAVE: begin
        cmp_a = cur_r;
        cmp_b = rd_data;
      end
      ST_MERGE: begin
        cmp_a = samp_r;
        cmp_b = cur_r;
      end
      default: begin
        cmp_a = rd_data;
        cmp_b = cur_r;
      end
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    win_len_nxt     = win_len_r;
    mode_nxt        = mode_r;
    rescan_pend_nxt = rescan_pend_r;
    ws_nxt          = ws_r;
    fill_nxt        = fill_r;
    samp_nxt        = samp_r;
    cur_nxt         = cur_r;
    covered_nxt     = covered_r;
    base_nxt        = base_r;
    full_nxt        = full_r;
    first_nxt       = first_r;
    scan_addr_nxt   = scan_addr_r;
    scan_left_nxt   = scan_left_r;
    rd_pend_nxt     = 1'b0;
    out_valid_nxt   = out_valid_r;
    out_ext_nxt     = out_ext_r;
    out_cov_nxt     = out_cov_r;

    mreq.we    = 1'b0;
    mreq.waddr = ws_r;
    mreq.wdata = in_sample;
    mreq.re    = 1'b0;
    mreq.raddr = leave_addr;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // Store the new sample and fetch the one that leaves the window.
          mreq.we     = 1'b1;
          mreq.re     = 1'b1;
          samp_nxt    = in_sample;
          base_nxt    = ws_r;
          full_nxt    = (fill_r >= win_eff);
          first_nxt   = (fill_r == '0);
          ws_nxt      = ws_r + SLOT_W'(1);
          fill_nxt    = fill_inc;
          covered_nxt = (fill_inc < win_eff) ? fill_inc : win_eff;
          state_nxt   = ST_LEAVE;
        end
      end
      ST_LEAVE: begin
        // A rescan is needed after reset or a register write, on the first sample, or
        // when the leaving sample was at least as good as the extremum.
        if (rescan_pend_r || first_r || (full_r && !cmp_better)) begin
          cur_nxt       = samp_r;
          scan_addr_nxt = base_r - SLOT_W'(1);
          scan_left_nxt = covered_r - WIN_W'(1);
          state_nxt     = ST_SCAN;
        end else begin
          state_nxt = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (cmp_better) begin
          cur_nxt = samp_r;
        end
        state_nxt = ST_OUT;
      end
      ST_SCAN: begin
        // One read issued and one compare retired per cycle.
        if (rd_pend_r && cmp_better) begin
          cur_nxt = rd_data;
        end
        if (scan_left_r != '0) begin
          mreq.re       = 1'b1;
          mreq.raddr    = scan_addr_r;
          rd_pend_nxt   = 1'b1;
          scan_addr_nxt = scan_addr_r - SLOT_W'(1);
          scan_left_nxt = scan_left_r - WIN_W'(1);
        end else if (!rd_pend_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_ext_nxt     = cur_r;
          out_cov_nxt     = covered_r;
          rescan_pend_nxt = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A register write in ST_IDLE or ST_OUT forces the next word to rescan.
    if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: begin
          win_len_nxt     = cfg_wdata;
          rescan_pend_nxt = 1'b1;
        end
        REG_MODE: begin
          mode_nxt        = cfg_wdata[0];
          rescan_pend_nxt = 1'b1;
        end
        default: begin
          rescan_pend_nxt = rescan_pend_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      win_len_r     <= WIN_RESET;
      mode_r        <= MODE_MAX;
      rescan_pend_r <= 1'b1;
      ws_r          <= '0;
      fill_r        <= '0;
      cur_r         <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      win_len_r     <= win_len_nxt;
      mode_r        <= mode_nxt;
      rescan_pend_r <= rescan_pend_nxt;
      ws_r          <= ws_nxt;
      fill_r        <= fill_nxt;
      cur_r         <= cur_nxt;
      rd_pend_r     <= rd_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r      <= samp_nxt;
    covered_r   <= covered_nxt;
    base_r      <= base_nxt;
    full_r      <= full_nxt;
    first_r     <= first_nxt;
    scan_addr_r <= scan_addr_nxt;
    scan_left_r <= scan_left_nxt;
    out_ext_r   <= out_ext_nxt;
    out_cov_r   <= out_cov_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_extremum = out_ext_r;
  assign out_covered  = out_cov_r;

endmodule
`default_nettype wire

// ===== src/rwe_hist_mem.sv =====
// History ring store of the rolling window extremum block.
// Depends on rwe_pkg; one write and one registered read per cycle, read-first.
`default_nettype none
module rwe_hist_mem (
  input  wire logic              clk,
  input  wire rwe_pkg::mem_req_t req,
  output rwe_pkg::sample_t       rd_data
);
  import rwe_pkg::*;

  sample_t mem_r [MAX_WINDOW];
  sample_t rd_data_r;

  // A read of the slot being written returns the old contents.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/rwe_cmp.sv =====
// Shared signed comparator of the rolling window extremum block.
// Depends on rwe_pkg; tells whether a is strictly better than b for the mode.
`default_nettype none
module rwe_cmp (
  input  wire rwe_pkg::sample_t a,
  input  wire rwe_pkg::sample_t b,
  input  wire logic             mode,
  output logic                  better
);
  import rwe_pkg::*;

  always_comb begin
    if (mode == MODE_MIN) begin
      better = (a < b);
    end else begin
      better = (a > b);
    end
  end

endmodule
`default_nettype wire

// ===== src/rwe_checker.sv =====
// Port-level checks for the rolling window extremum block, bound to the top.
// Depends on rwe_pkg and rolling_window_extremum.
`default_nettype none
module rwe_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire rwe_pkg::sample_t             out_extremum,
  input wire logic [rwe_pkg::WIN_W-1:0]    out_covered
);
  import rwe_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_extremum) && $stable(out_covered))
    else $error("result word changed while stalled");

  // The covered count is never zero and never beyond the ring depth.
  a_cov_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_covered != '0) && (out_covered <= WIN_MAX))
    else $error("covered count out of range");

  // One word at a time: the input closes right after a word is taken.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  // With no result waiting, none appears in the cycle right after a word is taken.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind rolling_window_extremum rwe_checker u_rwe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_extremum (out_extremum),
  .out_covered  (out_covered)
);
`default_nettype wire

// ===== tb/rolling_window_extremum_tb.sv =====
// Self-checking testbench for rolling_window_extremum: directed table, then random phases.
// Depends on rwe_pkg and the rolling_window_extremum RTL; needs nothing else to run.
`timescale 1ns / 1ps
module rolling_window_extremum_tb;
  import rwe_pkg::*;

  // A word that carries no result for longer than this many cycles means the block hung.
  localparam int QUIET_LIMIT = 20000;
  // Margin after the last result, a little above the longest rescan of a word.
  localparam int TAIL_CYCLES = 80;
  localparam int SEG_WORDS   = 210;

  typedef struct packed {
    sample_t           extremum;
    logic [WIN_W-1:0]  covered;
  } result_t;

  // One row of the directed table: a register write or one sample word.
  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [WIN_W-1:0]     wdata;
    sample_t              smp;
    bit                   typed;
    sample_t              t_ext;
    logic [WIN_W-1:0]     t_cov;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  sample_t              in_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              out_extremum;
  logic [WIN_W-1:0]     out_covered;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIN_W-1:0]     cfg_wdata = '0;

  // Typed expectations ride along with the word they belong to, so the monitor sees them
  // with the same timing as the payload.
  logic                 word_typed = 1'b0;
  sample_t              word_t_ext = '0;
  logic [WIN_W-1:0]     word_t_cov = '0;

  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   failures = 0;
  int                   quiet_cycles = 0;

  result_t              pending_results [$];

  // Mirror of the block state: sample ring, slot pointer, fill level, running extremum.
  sample_t              ring [MAX_WINDOW];
  logic [SLOT_W-1:0]    ring_slot = '0;
  int                   ring_fill = 0;
  sample_t              run_extremum = '0;
  bit                   rescan_due = 1'b1;
  logic [WIN_W-1:0]     win_reg = WIN_RESET;
  logic                 mode_reg = MODE_MAX;

  // Running value for the slowly trending part of the random samples.
  sample_t              trend_val = '0;
  int                   trend_step = -1;

  always #5 clk = ~clk;

  rolling_window_extremum u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_extremum (out_extremum),
    .out_covered  (out_covered),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // True when a is strictly better than b: larger in max mode, smaller in min mode.
  function automatic bit beats(sample_t a, sample_t b);
    return (mode_reg == MODE_MIN) ? (a < b) : (a > b);
  endfunction

  // A window register of zero behaves as one, anything above the ring depth as the depth.
  function automatic int live_window();
    int w;
    w = int'(win_reg);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;
    return w;
  endfunction

  // Walk back from the newest sample over the covered ones and keep the best.
  function automatic sample_t scan_ring(int covered_n);
    logic [SLOT_W-1:0] s;
    sample_t           best;
    s = ring_slot - 1'b1;
    best = ring[s];
    for (int i = 1; i < covered_n; i++) begin
      s = s - 1'b1;
      if (beats(ring[s], best)) best = ring[s];
    end
    return best;
  endfunction

  // Takes one sample into the mirrored state and returns the result the block owes for it.
  task automatic advance_window(input sample_t s, output result_t res);
    int      w;
    int      old_fill;
    int      covered_n;
    sample_t leaving;
    w = live_window();
    old_fill = ring_fill;
    leaving = '0;
    // The leaving sample is read before the new one may overwrite its slot.
    if (old_fill >= w) leaving = ring[SLOT_W'(int'(ring_slot) - w)];
    ring[ring_slot] = s;
    ring_slot = ring_slot + 1'b1;
    if (ring_fill < MAX_WINDOW) ring_fill++;
    covered_n = (ring_fill < w) ? ring_fill : w;
    if (rescan_due || old_fill == 0) begin
      run_extremum = scan_ring(covered_n);
    end else if (old_fill < w) begin
      // Window still filling: nothing leaves, so a merge is exact.
      if (beats(s, run_extremum)) run_extremum = s;
    end else if (!beats(run_extremum, leaving)) begin
      // The leaving sample was as good as the extremum, so it may have been it.
      run_extremum = scan_ring(covered_n);
    end else if (beats(s, run_extremum)) begin
      run_extremum = s;
    end
    rescan_due = 1'b0;
    res.extremum = run_extremum;
    res.covered  = WIN_W'(covered_n);
  endtask

  task automatic flag_failure(input string msg);
    if (failures < 10) $display("%0t: %s", $realtime, msg);
    failures++;
  endtask

  // The monitor samples every channel at the rising edge, where the block samples them too.
  // Register writes reach the mirror at the same edge as the block, and each accepted word
  // pushes its result; each accepted result is checked against the oldest one waiting.
  always @(posedge clk) begin : monitor
    result_t res;
    result_t want;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_LEN) begin
          win_reg = cfg_wdata;
          rescan_due = 1'b1;
        end else if (cfg_index == REG_MODE) begin
          mode_reg = cfg_wdata[0];
          rescan_due = 1'b1;
        end
      end
      if (in_valid && in_ready) begin
        advance_window(in_sample, res);
        if (word_typed) begin
          res.extremum = word_t_ext;
          res.covered  = word_t_cov;
        end
        pending_results.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_failure($sformatf("result with none expected: extremum %0d covered %0d",
                                 out_extremum, out_covered));
        end else begin
          want = pending_results.pop_front();
          if (out_extremum !== want.extremum)
            flag_failure($sformatf("extremum mismatch: expected %0d, got %0d",
                                   want.extremum, out_extremum));
          if (out_covered !== want.covered)
            flag_failure($sformatf("covered mismatch: expected %0d, got %0d",
                                   want.covered, out_covered));
        end
      end
    end
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // The watchdog ends the run when neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rolling_window_extremum_tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample word after random idle cycles and returns at the edge that takes it.
  // Valid stays high on return so that back-to-back words need no second assignment.
  task automatic push_word(input sample_t s, input bit typed, input sample_t t_ext,
                           input logic [WIN_W-1:0] t_cov);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sample  <= s;
    word_typed <= typed;
    word_t_ext <= t_ext;
    word_t_cov <= t_cov;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every expected result has come back, then waits a margin.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One register write: the enable is high for one edge and low for the next.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] val);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.wdata  = val;
    return r;
  endfunction

  function automatic row_t word_row(sample_t s);
    row_t r;
    r = '0;
    r.smp = s;
    return r;
  endfunction

  function automatic row_t typed_row(sample_t s, sample_t e, logic [WIN_W-1:0] c);
    row_t r;
    r = word_row(s);
    r.typed = 1'b1;
    r.t_ext = e;
    r.t_cov = c;
    return r;
  endfunction

  // Random samples mix full-range values, a narrow band that makes ties common, the
  // extremes, and slow trends; a falling trend in max mode evicts the extremum each word.
  function automatic sample_t next_sample();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return sample_t'($urandom);
    if (pick < 60) return sample_t'(int'($urandom_range(0, 7)) - 4);
    if (pick < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    if ($urandom_range(0, 31) == 0) begin
      trend_val  = sample_t'($urandom);
      trend_step = int'($urandom_range(0, 6)) - 3;
    end
    trend_val = trend_val + sample_t'(trend_step);
    return trend_val;
  endfunction

  initial begin : stimulus
    row_t              plan [$];
    row_t              r;
    int                seg_id;
    logic [WIN_W-1:0]  win_val;

    // After reset the window is 16 and the block tracks the maximum.
    plan.push_back(typed_row(32'sd5, 32'sd5, 7'd1));
    plan.push_back(typed_row(32'sh7fff_ffff, 32'sh7fff_ffff, 7'd2));
    plan.push_back(typed_row(32'sh8000_0000, 32'sh7fff_ffff, 7'd3));
    plan.push_back(word_row(-32'sd1));
    plan.push_back(word_row(32'sd0));
    // A window of zero acts as one: every result is the sample itself.
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd0));
    plan.push_back(typed_row(32'sh8000_0000, 32'sh8000_0000, 7'd1));
    plan.push_back(typed_row(32'sh7fff_ffff, 32'sh7fff_ffff, 7'd1));
    plan.push_back(cfg_row(REG_MODE, 7'(MODE_MIN)));
    plan.push_back(typed_row(32'sd3, 32'sd3, 7'd1));
    plan.push_back(typed_row(-32'sd3, -32'sd3, 7'd1));
    // A window above the ring depth acts as the full depth.
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd127));
    plan.push_back(word_row(32'sd10));
    plan.push_back(word_row(32'sh8000_0000));
    plan.push_back(word_row(32'sh7fff_ffff));
    // A short window with equal samples leaving, which forces rescans.
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd2));
    plan.push_back(word_row(32'sd1));
    plan.push_back(word_row(32'sd1));
    plan.push_back(word_row(32'sd2));
    plan.push_back(word_row(32'sd0));
    plan.push_back(cfg_row(REG_WINDOW_LEN, 7'd64));
    plan.push_back(cfg_row(REG_MODE, 7'h7e | 7'(MODE_MAX)));
    plan.push_back(word_row(32'sd4));
    plan.push_back(word_row(-32'sd4));
    plan.push_back(cfg_row(REG_WINDOW_LEN, WIN_RESET));
    plan.push_back(word_row(32'sh4000_0000));
    plan.push_back(word_row(-32'sh4000_0000));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) begin
        drain(4);
        write_reg(r.idx, r.wdata);
      end else begin
        push_word(r.smp, r.typed, r.t_ext, r.t_cov);
      end
    end

    // Random part: four idling phases, two register settings in each.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 87; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 87; end
        default: begin send_idle_pct <= 26; recv_stall_pct <= 26; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        seg_id = ph * 2 + seg;
        case (seg_id)
          0: win_val = 7'd64;
          1: win_val = 7'd5;
          2: win_val = 7'd0;
          3: win_val = 7'd127;
          4: win_val = 7'd1;
          5: win_val = 7'($urandom_range(1, 64));
          6: win_val = 7'd2;
          default: win_val = 7'($urandom_range(1, 16));
        endcase
        drain(4);
        write_reg(REG_WINDOW_LEN, win_val);
        // Upper data bits are don't-care for the mode register.
        write_reg(REG_MODE, {6'($urandom_range(0, 63)), 1'(seg_id % 2)});
        for (int n = 0; n < SEG_WORDS; n++) begin
          // Midway through each setting the sender waits for the block to run dry.
          if (n == SEG_WORDS / 2) drain(0);
          push_word(next_sample(), 1'b0, '0, '0);
        end
      end
    end

    drain(TAIL_CYCLES);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("rolling_window_extremum_tb passed");
    end else begin
      $display("rolling_window_extremum_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/rwe_pkg.sv
src/rwe_hist_mem.sv
src/rwe_cmp.sv
src/rolling_window_extremum.sv
src/rwe_checker.sv
tb/rolling_window_extremum_tb.sv
